/* sv/lrp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrp_pkg
// Shared types and codes of the table-driven shift-reduce parser engine.
// ----------------------------------------------------------------------------
package lrp_pkg;

  localparam logic [2:0] REQ_FEED     = 3'd0;
  localparam logic [2:0] REQ_WR_ACT   = 3'd1;
  localparam logic [2:0] REQ_WR_GOTO  = 3'd2;
  localparam logic [2:0] REQ_WR_RULE  = 3'd3;
  localparam logic [2:0] REQ_RST      = 3'd4;

  localparam logic [2:0] EV_REDUCE    = 3'd0;
  localparam logic [2:0] EV_SHIFT     = 3'd1;
  localparam logic [2:0] EV_SYNTAX    = 3'd2;
  localparam logic [2:0] EV_OVERFLOW  = 3'd3;
  localparam logic [2:0] EV_FAULT     = 3'd4;

  typedef enum logic [2:0] {
    CMD_FEED,
    CMD_WR_ACT,
    CMD_WR_GOTO,
    CMD_WR_RULE,
    CMD_RST
  } cmd_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [5:0]        symbol;
    logic [7:0]        table_state;
    logic signed [8:0] action_value;
    logic [7:0]        goto_target;
    logic [7:0]        rule_number;
    logic [5:0]        rule_lhs;
    logic [3:0]        rule_length;
  } item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] rule;
    logic [5:0] lhs;
    logic [7:0] state;
    logic [6:0] depth;
    logic       last;
  } evt_t;

endpackage

/* sv/lr_shift_reduce_parser_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_shift_reduce_parser_top
// Table-driven LR parser engine with a queued front end and a result queue.
// ----------------------------------------------------------------------------
// table writes and reset parse: done in the idle state as the engine pops them
// feed: a shift or error reads the action memory; each reduction adds the
//   registered rule, stack and goto memory reads done one after another
// a first result passes the front queue and the idle, read and act states
// reset clears parse state and queues; table and stack contents stay undefined
module lr_shift_reduce_parser_top #(
  parameter int STATE_COUNT      = 256,
  parameter int NUM_TERMINALS    = 64,
  parameter int NONTERM_COUNT    = 64,
  parameter int RULE_COUNT       = 256,
  parameter int STACK_DEPTH      = 64,
  parameter int MAX_REDUCE_CHAIN = 31
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [2:0]        req_type_i,
  input  logic [5:0]        symbol_i,
  input  logic [7:0]        table_state_i,
  input  logic signed [8:0] action_value_i,
  input  logic [7:0]        goto_target_i,
  input  logic [7:0]        rule_number_i,
  input  logic [5:0]        rule_lhs_i,
  input  logic [3:0]        rule_length_i,
  output logic              empty,
  input  logic              pop,
  output logic [2:0]        event_kind_o,
  output logic [7:0]        reduced_rule_o,
  output logic [5:0]        reduced_lhs_o,
  output logic [7:0]        current_state_o,
  output logic [6:0]        depth_now_o,
  output logic              last_o
);
  import lrp_pkg::*;

  item_t item;
  logic  item_valid, item_pop;
  evt_t  evt;

  lrp_front #(
    .STATE_COUNT  (STATE_COUNT),
    .NUM_TERMINALS(NUM_TERMINALS),
    .NONTERM_COUNT(NONTERM_COUNT),
    .RULE_COUNT   (RULE_COUNT)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .req_type_i    (req_type_i),
    .symbol_i      (symbol_i),
    .table_state_i (table_state_i),
    .action_value_i(action_value_i),
    .goto_target_i (goto_target_i),
    .rule_number_i (rule_number_i),
    .rule_lhs_i    (rule_lhs_i),
    .rule_length_i (rule_length_i),
    .item_o        (item),
    .item_valid_o  (item_valid),
    .item_pop_i    (item_pop)
  );

  lrp_back #(
    .STATE_COUNT     (STATE_COUNT),
    .NUM_TERMINALS   (NUM_TERMINALS),
    .NONTERM_COUNT   (NONTERM_COUNT),
    .RULE_COUNT      (RULE_COUNT),
    .STACK_DEPTH     (STACK_DEPTH),
    .MAX_REDUCE_CHAIN(MAX_REDUCE_CHAIN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .item_valid_i(item_valid),
    .item_pop_o  (item_pop),
    .empty       (empty),
    .pop         (pop),
    .evt_o       (evt)
  );

  assign event_kind_o    = evt.kind;
  assign reduced_rule_o  = evt.rule;
  assign reduced_lhs_o   = evt.lhs;
  assign current_state_o = evt.state;
  assign depth_now_o     = evt.depth;
  assign last_o          = evt.last;

endmodule

/* sv/lrp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrp_front
// Accepts items, classifies them, drops ignored ones, and queues the rest.
// ----------------------------------------------------------------------------
module lrp_front #(
  parameter int STATE_COUNT   = 256,
  parameter int NUM_TERMINALS = 64,
  parameter int NONTERM_COUNT = 64,
  parameter int RULE_COUNT    = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [2:0]          req_type_i,
  input  logic [5:0]          symbol_i,
  input  logic [7:0]          table_state_i,
  input  logic signed [8:0]   action_value_i,
  input  logic [7:0]          goto_target_i,
  input  logic [7:0]          rule_number_i,
  input  logic [5:0]          rule_lhs_i,
  input  logic [3:0]          rule_length_i,
  output lrp_pkg::item_t      item_o,
  output logic                item_valid_o,
  input  logic                item_pop_i
);
  import lrp_pkg::*;

  item_t      cls;
  logic       keep;
  logic       st_ok;
  item_t      q_mem [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  always_comb begin
    st_ok           = 32'(table_state_i) < STATE_COUNT;
    cls.symbol       = symbol_i;
    cls.table_state  = table_state_i;
    cls.action_value = action_value_i;
    cls.goto_target  = goto_target_i;
    cls.rule_number  = rule_number_i;
    cls.rule_lhs     = rule_lhs_i;
    cls.rule_length  = rule_length_i;
    cls.cmd          = CMD_FEED;
    keep             = 1'b0;
    case (req_type_i)
      REQ_FEED: begin
        cls.cmd = CMD_FEED;
        keep    = 1'b1;
      end
      REQ_WR_ACT: begin
        cls.cmd = CMD_WR_ACT;
        keep    = st_ok && (32'(symbol_i) < NUM_TERMINALS);
      end
      REQ_WR_GOTO: begin
        cls.cmd = CMD_WR_GOTO;
        keep    = st_ok && (32'(symbol_i) < NONTERM_COUNT);
      end
      REQ_WR_RULE: begin
        cls.cmd = CMD_WR_RULE;
        keep    = 32'(rule_number_i) < RULE_COUNT;
      end
      REQ_RST: begin
        cls.cmd = CMD_RST;
        keep    = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign full         = cnt_q == 2'd2;
  assign item_valid_o = cnt_q != 2'd0;
  assign item_o       = q_mem[rp_q];
  assign do_push      = push && !full && keep;
  assign do_pop       = item_pop_i && item_valid_o;

  always_comb begin
    wp_d  = do_push ? ~wp_q : wp_q;
    rp_d  = do_pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wp_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("front queue count beyond depth");
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full && !item_pop_i |=> full)
    else $error("front queue lost an item while full");
  a_ptr_eq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> (wp_q == rp_q))
    else $error("front queue pointers disagree when empty");

endmodule

/* sv/lrp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrp_back
// Parse engine: table memories, state stack, sequencer and result queue.
// ----------------------------------------------------------------------------
module lrp_back #(
  parameter int STATE_COUNT      = 256,
  parameter int NUM_TERMINALS    = 64,
  parameter int NONTERM_COUNT    = 64,
  parameter int RULE_COUNT       = 256,
  parameter int STACK_DEPTH      = 64,
  parameter int MAX_REDUCE_CHAIN = 31
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lrp_pkg::item_t item_i,
  input  logic           item_valid_i,
  output logic           item_pop_o,
  output logic           empty,
  input  logic           pop,
  output lrp_pkg::evt_t  evt_o
);
  import lrp_pkg::*;

  localparam int AAW = $clog2(STATE_COUNT * NUM_TERMINALS);
  localparam int GAW = $clog2(STATE_COUNT * NONTERM_COUNT);
  localparam int RW  = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;
  localparam int IW  = $clog2(STACK_DEPTH);
  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int OD  = 4;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RDACT = 3'd1;
  localparam logic [2:0] ST_ACT   = 3'd2;
  localparam logic [2:0] ST_RULE  = 3'd3;
  localparam logic [2:0] ST_STK   = 3'd4;
  localparam logic [2:0] ST_GOTO  = 3'd5;

  logic [8:0] act_mem  [STATE_COUNT * NUM_TERMINALS];
  logic [7:0] goto_mem [STATE_COUNT * NONTERM_COUNT];
  logic [9:0] rule_mem [RULE_COUNT];
  logic [7:0] stk_mem  [STACK_DEPTH];

  logic [2:0]    state_q, state_d;
  logic [7:0]    top_q, top_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [5:0]    chain_q, chain_d;
  logic [5:0]    sym_q, sym_d;
  logic [8:0]    rn_q, rn_d;
  logic [7:0]    exp_q, exp_d;
  logic          rng_q, rng_d;

  logic           act_we, goto_we, rule_we, stk_we;
  logic [AAW-1:0] act_wa, act_ra;
  logic [GAW-1:0] goto_wa, goto_ra;
  logic [RW-1:0]  rule_wa, rule_ra;
  logic [IW-1:0]  stk_wa, stk_ra;
  logic [7:0]     stk_wd;
  logic           act_re, goto_re, rule_re, stk_re;
  logic [8:0]     act_rd_q;
  logic [7:0]     goto_rd_q;
  logic [9:0]     rule_rd_q;
  logic [7:0]     stk_rd_q;

  logic              ofull;
  logic              emit;
  evt_t              ev;
  logic [2:0]        ev_kind;
  logic [7:0]        ev_rule;
  logic [5:0]        ev_lhs;
  logic              ev_last;
  logic signed [8:0] act;
  logic [5:0]        lhs;
  logic [3:0]        len;
  logic [CW-1:0]     base;
  logic [7:0]        expo;
  logic [31:0]       a32, g32, d32, r32;

  evt_t          o_mem [OD];
  logic [1:0]    owp_q, orp_q;
  logic [2:0]    ocnt_q;
  logic          opush, opop;

  assign act  = rng_q ? act_rd_q : 9'sd0;
  assign lhs  = rule_rd_q[9:4];
  assign len  = rule_rd_q[3:0];
  assign base = cnt_q - CW'(len);

  always_comb begin
    state_d    = state_q;
    top_d      = top_q;
    cnt_d      = cnt_q;
    chain_d    = chain_q;
    sym_d      = sym_q;
    rn_d       = rn_q;
    exp_d      = exp_q;
    rng_d      = rng_q;
    item_pop_o = 1'b0;
    act_we     = 1'b0;
    goto_we    = 1'b0;
    rule_we    = 1'b0;
    stk_we     = 1'b0;
    act_re     = 1'b0;
    goto_re    = 1'b0;
    rule_re    = 1'b0;
    stk_re     = 1'b0;
    a32        = 32'(item_i.table_state) * NUM_TERMINALS + 32'(item_i.symbol);
    g32        = 32'(item_i.table_state) * NONTERM_COUNT + 32'(item_i.symbol);
    r32        = 32'(item_i.rule_number);
    act_wa     = a32[AAW-1:0];
    goto_wa    = g32[GAW-1:0];
    rule_wa    = r32[RW-1:0];
    a32        = 32'(top_q) * NUM_TERMINALS + 32'(sym_q);
    act_ra     = a32[AAW-1:0];
    r32        = 32'(rn_q);
    rule_ra    = r32[RW-1:0];
    stk_ra     = base[IW-1:0];
    stk_wa     = cnt_q[IW-1:0];
    stk_wd     = top_q;
    expo       = (len == 4'd0) ? top_q : stk_rd_q;
    g32        = 32'(expo) * NONTERM_COUNT + 32'(lhs);
    goto_ra    = g32[GAW-1:0];
    emit       = 1'b0;
    ev_kind    = EV_FAULT;
    ev_rule    = 8'd0;
    ev_lhs     = 6'd0;
    ev_last    = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          case (item_i.cmd)
            CMD_FEED: begin
              sym_d   = item_i.symbol;
              chain_d = 6'd0;
              state_d = ST_RDACT;
            end
            CMD_WR_ACT:  act_we  = 1'b1;
            CMD_WR_GOTO: goto_we = 1'b1;
            CMD_WR_RULE: rule_we = 1'b1;
            CMD_RST: begin
              top_d = 8'd0;
              cnt_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_RDACT: begin
        act_re  = 1'b1;
        rng_d   = (32'(top_q) < STATE_COUNT) && (32'(sym_q) < NUM_TERMINALS);
        state_d = ST_ACT;
      end
      ST_ACT: begin
        if (!ofull) begin
          if (act == 9'sd0) begin
            emit    = 1'b1;
            ev_kind = EV_SYNTAX;
            state_d = ST_IDLE;
          end else if (!act[8]) begin
            emit    = 1'b1;
            state_d = ST_IDLE;
            if (32'(cnt_q) >= STACK_DEPTH) begin
              ev_kind = EV_OVERFLOW;
            end else begin
              ev_kind = EV_SHIFT;
              stk_we  = 1'b1;
              cnt_d   = cnt_q + CW'(1);
              top_d   = act[7:0];
            end
          end else begin
            rn_d = 9'(-act);
            if ((32'(chain_q) >= MAX_REDUCE_CHAIN) || (32'(rn_d) >= RULE_COUNT)) begin
              emit    = 1'b1;
              ev_kind = EV_FAULT;
              state_d = ST_IDLE;
            end else begin
              r32     = 32'(rn_d);
              rule_ra = r32[RW-1:0];
              rule_re = 1'b1;
              state_d = ST_RULE;
            end
          end
        end
      end
      ST_RULE: begin
        if (!ofull) begin
          if (CW'(len) > cnt_q || 32'(len) > 32'(cnt_q)) begin
            emit    = 1'b1;
            ev_kind = EV_FAULT;
            state_d = ST_IDLE;
          end else if ((len == 4'd0) && (32'(cnt_q) >= STACK_DEPTH)) begin
            emit    = 1'b1;
            ev_kind = EV_OVERFLOW;
            state_d = ST_IDLE;
          end else begin
            stk_re  = len != 4'd0;
            state_d = ST_STK;
          end
        end
      end
      ST_STK: begin
        goto_re = 1'b1;
        exp_d   = expo;
        rng_d   = (32'(expo) < STATE_COUNT) && (32'(lhs) < NONTERM_COUNT);
        state_d = ST_GOTO;
      end
      ST_GOTO: begin
        if (!ofull) begin
          emit = 1'b1;
          if (!rng_q || goto_rd_q == 8'd0) begin
            ev_kind = EV_FAULT;
            state_d = ST_IDLE;
          end else begin
            ev_kind = EV_REDUCE;
            ev_rule = rn_q[7:0];
            ev_lhs  = lhs;
            ev_last = 1'b0;
            stk_we  = 1'b1;
            stk_wa  = base[IW-1:0];
            stk_wd  = exp_q;
            cnt_d   = base + CW'(1);
            top_d   = goto_rd_q;
            chain_d = chain_q + 6'd1;
            state_d = ST_RDACT;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    d32      = 32'(cnt_d);
    ev.kind  = ev_kind;
    ev.rule  = ev_rule;
    ev.lhs   = ev_lhs;
    ev.state = top_d;
    ev.depth = d32[6:0];
    ev.last  = ev_last;
  end

  always_ff @(posedge clk_i) begin
    if (act_we) begin
      act_mem[act_wa] <= item_i.action_value;
    end
    if (act_re) begin
      act_rd_q <= act_mem[act_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (goto_we) begin
      goto_mem[goto_wa] <= item_i.goto_target;
    end
    if (goto_re) begin
      goto_rd_q <= goto_mem[goto_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rule_we) begin
      rule_mem[rule_wa] <= {item_i.rule_lhs, item_i.rule_length};
    end
    if (rule_re) begin
      rule_rd_q <= rule_mem[rule_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (stk_re) begin
      stk_rd_q <= stk_mem[stk_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q <= exp_d;
    rn_q  <= rn_d;
    sym_q <= sym_d;
    rng_q <= rng_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      top_q   <= 8'd0;
      cnt_q   <= '0;
      chain_q <= 6'd0;
    end else begin
      state_q <= state_d;
      top_q   <= top_d;
      cnt_q   <= cnt_d;
      chain_q <= chain_d;
    end
  end

  // result queue
  assign ofull = ocnt_q == 3'(OD);
  assign empty = ocnt_q == 3'd0;
  assign evt_o = o_mem[orp_q];
  assign opush = emit;
  assign opop  = pop && !empty;

  always_ff @(posedge clk_i) begin
    if (opush) begin
      o_mem[owp_q] <= ev;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owp_q  <= 2'd0;
      orp_q  <= 2'd0;
      ocnt_q <= 3'd0;
    end else begin
      owp_q  <= owp_q + 2'(opush);
      orp_q  <= orp_q + 2'(opop);
      ocnt_q <= ocnt_q + 3'(opush) - 3'(opop);
    end
  end

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= STACK_DEPTH)
    else $error("stack count beyond depth");
  a_oq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q <= 3'(OD))
    else $error("result queue count beyond depth");
  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> !ofull)
    else $error("result pushed into full queue");
  a_reduce_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && ev.kind == EV_REDUCE |-> !ev.last && state_d == ST_RDACT)
    else $error("reduce event closed the item");

endmodule
